// ===== rtl/bpge_pkg.sv =====
// Shared types, constants and gate codes for the bit-parallel gate evaluator.
package bpge_pkg;

  localparam int NET_COUNT = 1024;
  localparam int NET_W     = $clog2(NET_COUNT);
  localparam int LANES     = 64;
  localparam int WORD_W    = 64;
  localparam int SRC_MAX   = 4;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [WORD_W-1:0] ALL_ONES  = {WORD_W{1'b1}};
  localparam logic [WORD_W-1:0] LANE_MASK = ALL_ONES >> (WORD_W - LANES);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_GATE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [3:0] FN_AND    = 4'd0;
  localparam logic [3:0] FN_OR     = 4'd1;
  localparam logic [3:0] FN_NAND   = 4'd2;
  localparam logic [3:0] FN_NOR    = 4'd3;
  localparam logic [3:0] FN_XOR    = 4'd4;
  localparam logic [3:0] FN_XNOR   = 4'd5;
  localparam logic [3:0] FN_NOT    = 4'd6;
  localparam logic [3:0] FN_BUF    = 4'd7;
  localparam logic [3:0] FN_CONST0 = 4'd8;
  localparam logic [3:0] FN_CONST1 = 4'd9;
  localparam logic [3:0] FN_LUT    = 4'd10;

  localparam logic [1:0] LIT_ZERO = 2'd1;
  localparam logic [1:0] LIT_ONE  = 2'd2;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_GATE = 1'b1;

  typedef struct packed {
    logic [1:0]        command;
    logic [3:0]        func;
    logic [NET_W-1:0]  dest_net;
    logic [2:0]        src_count;
    logic [NET_W-1:0]  src_a;
    logic [NET_W-1:0]  src_b;
    logic [NET_W-1:0]  src_c;
    logic [NET_W-1:0]  src_d;
    logic [7:0]        cube_pattern;
    logic              cube_end;
    logic              gate_end;
    logic [WORD_W-1:0] word;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [NET_W-1:0]  net_index;
    logic [WORD_W-1:0] net_word;
  } result_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_GATE  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Decoded work word handed from front to back.
  typedef struct packed {
    op_t                          op;
    logic [3:0]                   func;
    logic [NET_W-1:0]             dest;
    logic [2:0]                   n;
    logic [SRC_MAX-1:0][NET_W-1:0] src;
    logic [7:0]                   pattern;
    logic                         cend;
    logic                         gend;
    logic [WORD_W-1:0]            word;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } queue_head_t;

endpackage

// ===== rtl/bpge_front.sv =====
// Front end: accept input words, classify them and queue the decoded work.
module bpge_front (
  input  logic                  clk,
  input  logic                  rst,
  input  bpge_pkg::item_t       item,
  input  logic                  item_valid,
  output logic                  item_stall,
  output bpge_pkg::queue_head_t head,
  input  logic                  pop
);
  import bpge_pkg::*;

  work_t             q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              take;
  work_t             dec;

  assign item_stall = (count == (QPTR_W+1)'(QDEPTH));
  assign take       = item_valid && !item_stall;
  assign push       = take && (cmd_t'(item.command) != CMD_NONE);

  always_comb begin
    dec         = '0;
    case (cmd_t'(item.command))
      CMD_WRITE: dec.op = OP_WRITE;
      CMD_GATE:  dec.op = OP_GATE;
      default:   dec.op = OP_READ;
    endcase
    dec.func    = item.func;
    dec.dest    = item.dest_net;
    // clamp fan-in to the chunk width
    dec.n       = (item.src_count > 3'(SRC_MAX)) ? 3'(SRC_MAX) : item.src_count;
    dec.src[0]  = item.src_a;
    dec.src[1]  = item.src_b;
    dec.src[2]  = item.src_c;
    dec.src[3]  = item.src_d;
    dec.pattern = item.cube_pattern;
    dec.cend    = item.cube_end;
    dec.gend    = item.gate_end;
    dec.word    = item.word;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  assign head.valid = (count != '0);
  assign head.work  = q[rd_ptr];

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH)) else $error("queue count overflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count lost a push");
`endif

endmodule

// ===== rtl/bpge_back.sv =====
// Back end: net store, source fetch, gate evaluation and result register.
module bpge_back (
  input  logic                  clk,
  input  logic                  rst,
  input  bpge_pkg::queue_head_t head,
  output logic                  pop,
  output bpge_pkg::result_t     result,
  output logic                  result_valid,
  input  logic                  result_stall
);
  import bpge_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SRC_CD,
    PH_EXEC
  } phase_t;

  logic [WORD_W-1:0] mem [NET_COUNT];

  phase_t            ph;
  work_t             cur;
  logic [NET_W-1:0]  addr0_held;
  logic [NET_W-1:0]  addr1_held;
  logic [NET_W-1:0]  rd_addr0;
  logic [NET_W-1:0]  rd_addr1;
  logic              rd_en;
  logic [WORD_W-1:0] rdata0;
  logic [WORD_W-1:0] rdata1;
  logic [WORD_W-1:0] wa;
  logic [WORD_W-1:0] wb;

  logic              fwd_valid;
  logic [NET_W-1:0]  fwd_addr;
  logic [WORD_W-1:0] fwd_data;

  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] cube_hit;
  logic              started;

  logic [WORD_W-1:0] acc_next;
  logic [WORD_W-1:0] cube_next;
  logic [WORD_W-1:0] val;
  logic              needs_out;
  logic              commit;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] srcw [SRC_MAX];
  logic [WORD_W-1:0] w;
  logic [1:0]        lit;

  assign needs_out = (cur.op == OP_READ) || (cur.op == OP_GATE && cur.gend);
  assign commit    = (ph == PH_EXEC) && (!needs_out || !result_valid || !result_stall);
  assign pop       = head.valid && ((ph == PH_IDLE) || commit);

  // Port 0 fetches the read target or src_a, then src_c; port 1 src_b, then src_d.
  assign rd_addr0 = (ph == PH_SRC_CD) ? cur.src[2] :
                    (head.work.op == OP_READ) ? head.work.dest : head.work.src[0];
  assign rd_addr1 = (ph == PH_SRC_CD) ? cur.src[3] : head.work.src[1];
  // hold the last two sources while exec waits on the result register
  assign rd_en    = pop || (ph == PH_SRC_CD);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata0 <= mem[rd_addr0];
      rdata1 <= mem[rd_addr1];
    end
    if (wr_en) begin
      mem[cur.dest] <= wr_data;
    end
  end

  assign srcw[0] = wa;
  assign srcw[1] = wb;
  assign srcw[2] = rdata0;
  assign srcw[3] = rdata1;

  always_comb begin
    w         = '0;
    lit       = '0;
    acc_next  = started ? acc : '0;
    cube_next = started ? cube_hit : ALL_ONES;
    if (!started) begin
      if (cur.func == FN_NOT || cur.func == FN_BUF) begin
        acc_next = (cur.n != '0) ? wa : '0;
      end else if (cur.func == FN_AND || cur.func == FN_NAND) begin
        acc_next = ALL_ONES;
      end else begin
        acc_next = '0;
      end
    end
    for (int j = 0; j < SRC_MAX; j++) begin
      if (3'(j) < cur.n) begin
        w   = srcw[j];
        lit = cur.pattern[2*j +: 2];
        case (cur.func)
          FN_AND, FN_NAND: acc_next = acc_next & w;
          FN_OR, FN_NOR:   acc_next = acc_next | w;
          FN_XOR, FN_XNOR: acc_next = acc_next ^ w;
          FN_LUT: begin
            if (lit == LIT_ZERO) begin
              cube_next = cube_next & ~w;
            end else if (lit == LIT_ONE) begin
              cube_next = cube_next & w;
            end
          end
          default: ;
        endcase
      end
    end
    if (cur.func == FN_LUT && cur.cend) begin
      acc_next  = acc_next | cube_next;
      cube_next = ALL_ONES;
    end
    case (cur.func)
      FN_AND, FN_OR, FN_XOR, FN_BUF, FN_LUT:  val = acc_next & LANE_MASK;
      FN_NAND, FN_NOR, FN_XNOR, FN_NOT:       val = ~acc_next & LANE_MASK;
      FN_CONST1:                              val = LANE_MASK;
      default:                                val = '0;
    endcase
  end

  assign wr_en   = commit && ((cur.op == OP_WRITE) || (cur.op == OP_GATE && cur.gend));
  assign wr_data = (cur.op == OP_WRITE) ? (cur.word & LANE_MASK) : val;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph           <= PH_IDLE;
      result_valid <= 1'b0;
      fwd_valid    <= 1'b0;
      acc          <= '0;
      cube_hit     <= ALL_ONES;
      started      <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (commit) begin
        if (needs_out) begin
          result_valid <= 1'b1;
        end
        if (cur.op == OP_GATE) begin
          if (cur.gend) begin
            acc      <= '0;
            cube_hit <= ALL_ONES;
            started  <= 1'b0;
          end else begin
            acc      <= acc_next;
            cube_hit <= cube_next;
            started  <= 1'b1;
          end
        end
      end
      case (ph)
        PH_IDLE:   ph <= pop ? PH_SRC_CD : PH_IDLE;
        PH_SRC_CD: ph <= PH_EXEC;
        PH_EXEC:   ph <= pop ? PH_SRC_CD : (commit ? PH_IDLE : PH_EXEC);
        default:   ph <= PH_IDLE;
      endcase
    end
  end

  // Payload registers: work in flight, forwarded sources and the result.
  always_ff @(posedge clk) begin
    fwd_addr <= cur.dest;
    fwd_data <= wr_data;
    if (pop) begin
      cur        <= head.work;
      addr0_held <= rd_addr0;
      addr1_held <= rd_addr1;
    end
    if (ph == PH_SRC_CD) begin
      // bypass the store when the last write landed at the same edge as the fetch
      wa <= (fwd_valid && fwd_addr == addr0_held) ? fwd_data : rdata0;
      wb <= (fwd_valid && fwd_addr == addr1_held) ? fwd_data : rdata1;
    end
    if (commit && needs_out) begin
      result.kind      <= (cur.op == OP_READ) ? KIND_READ : KIND_GATE;
      result.net_index <= cur.dest;
      result.net_word  <= (cur.op == OP_READ) ? (wa & LANE_MASK) : val;
    end
  end

`ifndef ASSERT_OFF
  a_fetch_then_exec: assert property (@(posedge clk) disable iff (rst)
    (ph == PH_SRC_CD) |=> (ph == PH_EXEC)) else $error("fetch not followed by exec");
  a_pop_phase: assert property (@(posedge clk) disable iff (rst)
    pop |-> (ph != PH_SRC_CD)) else $error("pop during source fetch");
  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (ph == PH_EXEC)) else $error("store write outside exec");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (commit && needs_out) |-> (!result_valid || !result_stall))
    else $error("result overwritten while stalled");
`endif

endmodule

// ===== rtl/bit_parallel_gate_evaluator.sv =====
// Top level of the bit-parallel gate evaluator.
// The block simulates a gate netlist on 64 patterns at once, one bit per lane, against a
// 1024-entry store of 64-bit net words. Each input word is a write, a gate chunk of up to
// four sources, or a read; a finished gate and a read each return one result word. The
// store's two read ports fetch the first two sources as a word leaves the queue, then the
// last two; evaluation and write-back of one word overlap the fetch of the next, as the
// next word is popped when the current one commits. A write that lands as the next word
// fetches is forwarded. A four-entry queue separates the front end from the back end, and
// the result register lets words that return no result proceed while a result waits.
// Nets must be written before they are read; the store has no reset.
module bit_parallel_gate_evaluator (
  input  logic              clk,
  input  logic              rst,
  input  bpge_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_stall,
  output bpge_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_stall
);
  import bpge_pkg::*;

  queue_head_t head;
  logic        pop;

  // classify and queue incoming words
  bpge_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .head       (head),
    .pop        (pop)
  );

  // fetch sources, evaluate, write back and report
  bpge_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
